[design/biquad_iir_filter_macros.svh]
// Assertion macros for the files that check their own logic.
`ifndef BIQUAD_IIR_FILTER_MACROS_SVH
`define BIQUAD_IIR_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BQF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biquad assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BQF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biquad assertion failed");

`endif

[design/bqf_pkg.sv]
`default_nettype none

package bqf_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 20;
    localparam int COEF_FRAC    = COEF_WIDTH - 2;
    localparam int DELAY_WIDTH  = 40;
    localparam int NUM_COEFS    = 5;
    localparam int PROD_WIDTH   = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_WIDTH    =
        ((PROD_WIDTH > DELAY_WIDTH) ? PROD_WIDTH : DELAY_WIDTH) + 2;
    localparam int IDX_WIDTH    = $clog2(NUM_COEFS);

    // Register indexes of the configuration port.
    localparam logic [IDX_WIDTH-1:0] IDX_B0 = IDX_WIDTH'(0);
    localparam logic [IDX_WIDTH-1:0] IDX_B1 = IDX_WIDTH'(1);
    localparam logic [IDX_WIDTH-1:0] IDX_B2 = IDX_WIDTH'(2);
    localparam logic [IDX_WIDTH-1:0] IDX_A1 = IDX_WIDTH'(3);
    localparam logic [IDX_WIDTH-1:0] IDX_A2 = IDX_WIDTH'(4);

    // Unity gain in Q2.FRAC.
    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MB0  = 7'b0000010,
        ST_RND  = 7'b0000100,
        ST_MA1  = 7'b0001000,
        ST_MB2  = 7'b0010000,
        ST_MA2  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

[design/bqf_mul.sv]
`default_nettype none

// Shared signed multiplier with a registered product.
module bqf_mul (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_en,
    input  wire logic signed [bqf_pkg::COEF_WIDTH-1:0]   i_coef,
    input  wire logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] i_smp,
    output logic signed      [bqf_pkg::PROD_WIDTH-1:0]   o_prod
);

    logic signed [bqf_pkg::PROD_WIDTH-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= bqf_pkg::PROD_WIDTH'(i_coef) * bqf_pkg::PROD_WIDTH'(i_smp);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[design/biquad_iir_filter.sv]
// Each sample passes through the states MB0, RND, MA1, MB2, MA2 and FIN before its result
// enters the output register; the single shared multiplier forms the five coefficient
// products one per cycle, and the next sample is taken in the last step, FIN.
// Reset (synchronous, active low) clears both delays, restores b0 to unity and the
// other coefficients to zero, and empties the output register.
`default_nettype none

module biquad_iir_filter (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_cfg_we,
    input  wire logic [bqf_pkg::IDX_WIDTH-1:0]           i_cfg_idx,
    input  wire logic [bqf_pkg::COEF_WIDTH-1:0]          i_cfg_data,
    input  wire logic                                     i_valid,
    output logic                                          o_ready,
    input  wire logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] i_sample_in,
    input  wire logic                                     i_restart,
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output logic signed      [bqf_pkg::SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                                          o_clipped
);

`include "biquad_iir_filter_macros.svh"

    localparam int SW  = bqf_pkg::SAMPLE_WIDTH;
    localparam int CW  = bqf_pkg::COEF_WIDTH;
    localparam int DW  = bqf_pkg::DELAY_WIDTH;
    localparam int AW  = bqf_pkg::ACC_WIDTH;
    localparam int PW  = bqf_pkg::PROD_WIDTH;
    localparam int FR  = bqf_pkg::COEF_FRAC;
    localparam int SHW = AW - FR;

    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) << (FR - 1);
    localparam logic signed [SW-1:0] SMP_MAX    = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN    = {1'b1, {(SW - 1){1'b0}}};
    localparam logic signed [DW-1:0] DLY_MAX    = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] DLY_MIN    = {1'b1, {(DW - 1){1'b0}}};

    // Saturate a wide sum to the delay range.
    function automatic logic signed [DW-1:0] sat_delay(input logic signed [AW-1:0] v);
        logic [AW-DW:0] hi;
        hi = v[AW-1:DW-1];
        if ((&hi) || !(|hi)) begin
            return v[DW-1:0];
        end else if (v[AW-1]) begin
            return DLY_MIN;
        end else begin
            return DLY_MAX;
        end
    endfunction

    bqf_pkg::t_state r_state;

    logic signed [CW-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [DW-1:0] r_d1, r_d2;
    logic signed [SW-1:0] r_x, r_y;
    logic                 r_clip;
    logic signed [AW-1:0] r_acc;
    logic                 r_ovalid;
    logic signed [SW-1:0] r_osample;
    logic                 r_oclip;

    logic signed [CW-1:0]  w_coef;
    logic signed [SW-1:0]  w_smp;
    logic                  w_mul_en;
    logic signed [PW-1:0]  w_prod;
    logic                  w_out_free;
    logic                  w_accept;
    logic signed [AW-1:0]  w_sum;
    logic signed [SHW-1:0] w_shift;
    logic [SHW-SW:0]       w_hi;
    logic signed [SW-1:0]  w_y;
    logic                  w_clip;

    assign w_out_free = !r_ovalid || i_ready;
    assign o_ready    = (r_state == bqf_pkg::ST_IDLE)
                     || ((r_state == bqf_pkg::ST_FIN) && w_out_free);
    assign w_accept   = i_valid && o_ready;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_en = 1'b1;
        unique case (r_state)
            bqf_pkg::ST_MB0: begin w_coef = r_b0; w_smp = r_x; end
            bqf_pkg::ST_RND: begin w_coef = r_b1; w_smp = r_x; end
            bqf_pkg::ST_MA1: begin w_coef = r_a1; w_smp = r_y; end
            bqf_pkg::ST_MB2: begin w_coef = r_b2; w_smp = r_x; end
            bqf_pkg::ST_MA2: begin w_coef = r_a2; w_smp = r_y; end
            default: begin
                w_coef   = r_b0;
                w_smp    = r_x;
                w_mul_en = 1'b0;
            end
        endcase
    end

    bqf_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_coef (w_coef),
        .i_smp  (w_smp),
        .o_prod (w_prod)
    );

    // Output sample: round half up, floor, then saturate.
    always_comb begin
        w_sum   = AW'(w_prod) + AW'(r_d1) + ROUND_HALF;
        w_shift = w_sum[AW-1:FR];
        w_hi    = w_shift[SHW-1:SW-1];
        if ((&w_hi) || !(|w_hi)) begin
            w_y    = w_shift[SW-1:0];
            w_clip = 1'b0;
        end else if (w_shift[SHW-1]) begin
            w_y    = SMP_MIN;
            w_clip = 1'b1;
        end else begin
            w_y    = SMP_MAX;
            w_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= bqf_pkg::COEF_ONE;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bqf_pkg::IDX_B0: r_b0 <= i_cfg_data;
                bqf_pkg::IDX_B1: r_b1 <= i_cfg_data;
                bqf_pkg::IDX_B2: r_b2 <= i_cfg_data;
                bqf_pkg::IDX_A1: r_a1 <= i_cfg_data;
                bqf_pkg::IDX_A2: r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bqf_pkg::ST_IDLE;
            r_d1     <= '0;
            r_d2     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Loading a new result takes precedence over emptying the output register.
            if ((r_state == bqf_pkg::ST_FIN) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                bqf_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= bqf_pkg::ST_MB0;
                        if (i_restart) begin
                            r_d1 <= '0;
                            r_d2 <= '0;
                        end
                    end
                end
                bqf_pkg::ST_MB0: r_state <= bqf_pkg::ST_RND;
                bqf_pkg::ST_RND: begin
                    r_y     <= w_y;
                    r_clip  <= w_clip;
                    r_state <= bqf_pkg::ST_MA1;
                end
                bqf_pkg::ST_MA1: begin
                    r_acc   <= AW'(w_prod) + AW'(r_d2);
                    r_state <= bqf_pkg::ST_MB2;
                end
                bqf_pkg::ST_MB2: begin
                    r_d1    <= sat_delay(r_acc - AW'(w_prod));
                    r_state <= bqf_pkg::ST_MA2;
                end
                bqf_pkg::ST_MA2: begin
                    r_acc   <= AW'(w_prod);
                    r_state <= bqf_pkg::ST_FIN;
                end
                bqf_pkg::ST_FIN: begin
                    // Hold here until the output register can take the result.
                    if (w_out_free) begin
                        // A restart clears the delays before the next sample uses them.
                        if (w_accept && i_restart) begin
                            r_d1 <= '0;
                            r_d2 <= '0;
                        end else begin
                            r_d2 <= sat_delay(r_acc - AW'(w_prod));
                        end
                        r_osample <= r_y;
                        r_oclip   <= r_clip;
                        r_state   <= w_accept ? bqf_pkg::ST_MB0 : bqf_pkg::ST_IDLE;
                    end
                end
                default: r_state <= bqf_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_sample_in;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_sample_out = r_osample;
    assign o_clipped    = r_oclip;

    `BQF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == bqf_pkg::ST_MB0)
    `BQF_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, w_accept && i_restart,
                     (r_d1 == '0) && (r_d2 == '0))
    `BQF_ASSERT_NEXT(a_fin_loads_out, i_clk, i_rst_n,
                     (r_state == bqf_pkg::ST_FIN) && w_out_free, o_valid)
    `BQF_ASSERT_SAME(a_clip_at_rail, i_clk, i_rst_n, o_valid && o_clipped,
                     (o_sample_out == SMP_MAX) || (o_sample_out == SMP_MIN))

endmodule

`default_nettype wire
